FILE: sv/ats_pkg.sv
// shared types, constants and keyword lookup for the assembly token scanner
`default_nettype none

package ats_pkg;

    localparam int ATS_POSITION_BITS = 16;
    localparam int ATS_OFFSET_BITS   = 24;
    localparam int ATS_LENGTH_BITS   = 8;
    localparam int ATS_QUEUE_DEPTH   = 4;

    localparam int KIND_BITS   = 5;
    localparam int CHAR_BITS   = 8;
    localparam int PREFIX_BITS = 32;
    localparam int NUMBER_BITS = 64;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_WORD    = 5'b00010,
        MODE_NUMBER  = 5'b00100,
        MODE_COMMENT = 5'b01000,
        MODE_DONE    = 5'b10000
    } t_mode;

    localparam logic [KIND_BITS-1:0] KIND_END      = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_COMMA    = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_HALT     = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_ADD      = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_SUB      = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_MUL      = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_DIV      = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_PUSH     = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_POP      = 5'd8;
    localparam logic [KIND_BITS-1:0] KIND_MOVE     = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_CMP      = 5'd10;
    localparam logic [KIND_BITS-1:0] KIND_JMP      = 5'd11;
    localparam logic [KIND_BITS-1:0] KIND_JE       = 5'd12;
    localparam logic [KIND_BITS-1:0] KIND_JNE      = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_JG       = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_JL       = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_JGE      = 5'd16;
    localparam logic [KIND_BITS-1:0] KIND_JLE      = 5'd17;
    localparam logic [KIND_BITS-1:0] KIND_RA       = 5'd18;
    localparam logic [KIND_BITS-1:0] KIND_RB       = 5'd19;
    localparam logic [KIND_BITS-1:0] KIND_RC       = 5'd20;
    localparam logic [KIND_BITS-1:0] KIND_RD       = 5'd21;
    localparam logic [KIND_BITS-1:0] KIND_LABEL    = 5'd22;
    localparam logic [KIND_BITS-1:0] KIND_IDENT    = 5'd23;
    localparam logic [KIND_BITS-1:0] KIND_IMM      = 5'd24;
    localparam logic [KIND_BITS-1:0] KIND_ILLEGAL  = 5'd25;
    localparam logic [KIND_BITS-1:0] KIND_OVERFLOW = 5'd26;

    localparam logic [CHAR_BITS-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_COMMA   = 8'h2C;
    localparam logic [CHAR_BITS-1:0] CH_DIGIT0  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_DIGIT9  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_COLON   = 8'h3A;
    localparam logic [CHAR_BITS-1:0] CH_SEMI    = 8'h3B;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = 8'h7A;

    // word length is 1..4 here, 0 means too long or empty
    function automatic logic [KIND_BITS-1:0] kw_kind(input logic [PREFIX_BITS-1:0] w,
                                                     input logic [2:0] n);
        logic [KIND_BITS-1:0] kind;
        kind = KIND_END;
        case (n)
            3'd4: begin
                if (w == "halt") kind = KIND_HALT;
                else if (w == "push") kind = KIND_PUSH;
                else if (w == "move") kind = KIND_MOVE;
            end
            3'd3: begin
                if (w == {8'h00, "add"}) kind = KIND_ADD;
                else if (w == {8'h00, "sub"}) kind = KIND_SUB;
                else if (w == {8'h00, "mul"}) kind = KIND_MUL;
                else if (w == {8'h00, "div"}) kind = KIND_DIV;
                else if (w == {8'h00, "pop"}) kind = KIND_POP;
                else if (w == {8'h00, "cmp"}) kind = KIND_CMP;
                else if (w == {8'h00, "jmp"}) kind = KIND_JMP;
                else if (w == {8'h00, "jne"}) kind = KIND_JNE;
                else if (w == {8'h00, "jge"}) kind = KIND_JGE;
                else if (w == {8'h00, "jle"}) kind = KIND_JLE;
            end
            3'd2: begin
                if (w == {16'h0000, "je"}) kind = KIND_JE;
                else if (w == {16'h0000, "jg"}) kind = KIND_JG;
                else if (w == {16'h0000, "jl"}) kind = KIND_JL;
                else if (w == {16'h0000, "RA"}) kind = KIND_RA;
                else if (w == {16'h0000, "RB"}) kind = KIND_RB;
                else if (w == {16'h0000, "RC"}) kind = KIND_RC;
                else if (w == {16'h0000, "RD"}) kind = KIND_RD;
            end
            default: kind = KIND_END;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

FILE: sv/ats_result_fifo.sv
// result queue taking up to two results per cycle and giving one per transfer
`default_nettype none

module ats_result_fifo
    import ats_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = ATS_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [1:0]       i_push_cnt,
    input  wire logic [WIDTH-1:0] i_push_data0,
    input  wire logic [WIDTH-1:0] i_push_data1,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_room2
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             pop_ok;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room2 = (r_cnt <= CW'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PW'(i_push_cnt);
            r_rd  <= r_rd + PW'(pop_ok);
            r_cnt <= r_cnt + CW'(i_push_cnt) - CW'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push_data0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr + PW'(1)] <= i_push_data1;
        end
    end

endmodule

`default_nettype wire

FILE: sv/assembly_token_scanner_top.sv
// a byte's results are written into the result queue when the byte is transferred
// throughput: one byte per cycle; a comma, end or illegal byte ending a word or a number
// that did not overflow yields two results, which leave at one per cycle unless i_stall,
// via a four-entry result queue; the input stalls while the queue has under two free entries
// reset is synchronous: scanner idle at line 1, column 1, offset 0, queue empty
`default_nettype none

module assembly_token_scanner_top
    import ats_pkg::*;
#(
    parameter int POSITION_BITS = ATS_POSITION_BITS,
    parameter int OFFSET_BITS   = ATS_OFFSET_BITS,
    parameter int LENGTH_BITS   = ATS_LENGTH_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [CHAR_BITS-1:0]     i_char_byte,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [KIND_BITS-1:0]          o_token_kind,
    output logic [POSITION_BITS-1:0]      o_start_line,
    output logic [POSITION_BITS-1:0]      o_start_column,
    output logic [OFFSET_BITS-1:0]        o_start_offset,
    output logic [LENGTH_BITS-1:0]        o_token_length,
    output logic                          o_last_of_run
);

    localparam int P  = POSITION_BITS;
    localparam int O  = OFFSET_BITS;
    localparam int L  = LENGTH_BITS;
    localparam int RW = KIND_BITS + 2 * P + O + L + 1;

    t_mode                  r_mode,   n_mode;
    logic [P-1:0]           r_line,   n_line;
    logic [P-1:0]           r_col,    n_col;
    logic [O-1:0]           r_off,    n_off;
    logic [P-1:0]           r_tline,  n_tline;
    logic [P-1:0]           r_tcol,   n_tcol;
    logic [O-1:0]           r_toff,   n_toff;
    logic [L-1:0]           r_len,    n_len;
    logic [PREFIX_BITS-1:0] r_prefix, n_prefix;
    logic [NUMBER_BITS-1:0] r_num,    n_num;
    logic                   r_ovf,    n_ovf;

    logic                   accept;
    logic [CHAR_BITS-1:0]   b;
    logic                   is_alpha, is_digit, is_space;
    logic [P-1:0]           adv_line, adv_col;
    logic [O-1:0]           adv_off;
    logic [L-1:0]           len_up;
    logic [2:0]             kw_len;
    logic [KIND_BITS-1:0]   kw;
    logic [NUMBER_BITS+3:0] num_next;
    logic                   run_idle;

    logic                   tok_v;
    logic [KIND_BITS-1:0]   tok_kind;
    logic [P-1:0]           tok_line, tok_col;
    logic [O-1:0]           tok_off;
    logic [L-1:0]           tok_len;
    logic                   idl_v;
    logic [KIND_BITS-1:0]   idl_kind;
    logic [L-1:0]           idl_len;

    logic [1:0]             push_cnt;
    logic [RW-1:0]          rec_tok, rec_idl, push0, push1, out_rec;
    logic                   room2;

    assign accept   = i_valid && !o_stall;
    assign b        = i_char_byte;
    assign is_alpha = ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ||
                      ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z));
    assign is_digit = (b >= CH_DIGIT0) && (b <= CH_DIGIT9);
    assign is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

    assign adv_line = ((b == CH_NEWLINE) && (r_line != '1)) ? r_line + P'(1) : r_line;
    assign adv_col  = (b == CH_NEWLINE) ? P'(1) : ((r_col != '1) ? r_col + P'(1) : r_col);
    assign adv_off  = (r_off != '1) ? r_off + O'(1) : r_off;
    assign len_up   = (r_len != '1) ? r_len + L'(1) : r_len;
    assign kw_len   = (r_len <= L'(4)) ? r_len[2:0] : 3'd0;
    assign kw       = kw_kind(r_prefix, kw_len);

    // times ten plus digit, top bits flag a value past 64 bits
    assign num_next = ({4'b0000, r_num} << 3) + ({4'b0000, r_num} << 1) +
                      (NUMBER_BITS + 4)'(b[3:0]);

    always_comb begin
        n_mode   = r_mode;
        n_line   = r_line;
        n_col    = r_col;
        n_off    = r_off;
        n_tline  = r_tline;
        n_tcol   = r_tcol;
        n_toff   = r_toff;
        n_len    = r_len;
        n_prefix = r_prefix;
        n_num    = r_num;
        n_ovf    = r_ovf;
        run_idle = 1'b0;
        tok_v    = 1'b0;
        tok_kind = KIND_END;
        tok_line = r_tline;
        tok_col  = r_tcol;
        tok_off  = r_toff;
        tok_len  = r_len;
        idl_v    = 1'b0;
        idl_kind = KIND_END;
        idl_len  = '0;

        unique case (r_mode)
            MODE_IDLE: begin
                run_idle = 1'b1;
            end
            MODE_WORD: begin
                if (is_alpha) begin
                    n_prefix = {r_prefix[PREFIX_BITS-CHAR_BITS-1:0], b};
                    n_len    = len_up;
                    n_line   = adv_line;
                    n_col    = adv_col;
                    n_off    = adv_off;
                end else begin
                    n_mode = MODE_IDLE;
                    tok_v  = 1'b1;
                    if (kw != KIND_END) begin
                        tok_kind = kw;
                        run_idle = 1'b1;
                    end else if (b == CH_COLON) begin
                        tok_kind = KIND_LABEL;
                        n_line   = adv_line;
                        n_col    = adv_col;
                        n_off    = adv_off;
                    end else begin
                        tok_kind = KIND_IDENT;
                        run_idle = 1'b1;
                    end
                end
            end
            MODE_NUMBER: begin
                if (is_digit) begin
                    n_ovf  = r_ovf || (num_next[NUMBER_BITS+3:NUMBER_BITS] != 4'd0);
                    n_num  = num_next[NUMBER_BITS-1:0];
                    n_len  = len_up;
                    n_line = adv_line;
                    n_col  = adv_col;
                    n_off  = adv_off;
                end else if (r_ovf) begin
                    tok_v    = 1'b1;
                    tok_kind = KIND_OVERFLOW;
                    n_tline  = r_line;
                    n_tcol   = r_col;
                    n_toff   = r_off;
                    n_mode   = MODE_DONE;
                end else begin
                    tok_v    = 1'b1;
                    tok_kind = KIND_IMM;
                    n_mode   = MODE_IDLE;
                    run_idle = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (b == CH_NUL) begin
                    tok_v    = 1'b1;
                    tok_kind = KIND_END;
                    tok_line = r_line;
                    tok_col  = r_col;
                    tok_off  = r_off;
                    tok_len  = '0;
                    n_tline  = r_line;
                    n_tcol   = r_col;
                    n_toff   = r_off;
                    n_mode   = MODE_DONE;
                end else begin
                    if (b == CH_NEWLINE) begin
                        n_mode = MODE_IDLE;
                    end
                    n_line = adv_line;
                    n_col  = adv_col;
                    n_off  = adv_off;
                end
            end
            MODE_DONE: begin
                tok_v    = 1'b1;
                tok_kind = KIND_END;
                tok_len  = '0;
            end
            default: begin
                n_mode   = MODE_DONE;
                tok_v    = 1'b1;
                tok_kind = KIND_END;
                tok_len  = '0;
            end
        endcase

        if (run_idle) begin
            if (b == CH_NUL) begin
                idl_v    = 1'b1;
                idl_kind = KIND_END;
                idl_len  = '0;
                n_tline  = r_line;
                n_tcol   = r_col;
                n_toff   = r_off;
                n_mode   = MODE_DONE;
            end else if (is_space) begin
                n_line = adv_line;
                n_col  = adv_col;
                n_off  = adv_off;
            end else if (b == CH_SEMI) begin
                n_mode = MODE_COMMENT;
                n_line = adv_line;
                n_col  = adv_col;
                n_off  = adv_off;
            end else if (b == CH_COMMA) begin
                idl_v    = 1'b1;
                idl_kind = KIND_COMMA;
                idl_len  = L'(1);
                n_line   = adv_line;
                n_col    = adv_col;
                n_off    = adv_off;
            end else if (is_alpha) begin
                n_tline  = r_line;
                n_tcol   = r_col;
                n_toff   = r_off;
                n_len    = L'(1);
                n_prefix = {{(PREFIX_BITS - CHAR_BITS){1'b0}}, b};
                n_mode   = MODE_WORD;
                n_line   = adv_line;
                n_col    = adv_col;
                n_off    = adv_off;
            end else if (is_digit) begin
                n_tline = r_line;
                n_tcol  = r_col;
                n_toff  = r_off;
                n_len   = L'(1);
                n_num   = NUMBER_BITS'(b[3:0]);
                n_ovf   = 1'b0;
                n_mode  = MODE_NUMBER;
                n_line  = adv_line;
                n_col   = adv_col;
                n_off   = adv_off;
            end else begin
                idl_v    = 1'b1;
                idl_kind = KIND_ILLEGAL;
                idl_len  = L'(1);
                n_tline  = r_line;
                n_tcol   = r_col;
                n_toff   = r_off;
                n_mode   = MODE_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_line   <= P'(1);
            r_col    <= P'(1);
            r_off    <= '0;
            r_tline  <= P'(1);
            r_tcol   <= P'(1);
            r_toff   <= '0;
            r_len    <= '0;
            r_prefix <= '0;
            r_num    <= '0;
            r_ovf    <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_line   <= n_line;
            r_col    <= n_col;
            r_off    <= n_off;
            r_tline  <= n_tline;
            r_tcol   <= n_tcol;
            r_toff   <= n_toff;
            r_len    <= n_len;
            r_prefix <= n_prefix;
            r_num    <= n_num;
            r_ovf    <= n_ovf;
        end
    end

    // pack results, the last one of the byte gets the run flag
    always_comb begin
        rec_tok  = {tok_kind, tok_line, tok_col, tok_off, tok_len, !idl_v};
        rec_idl  = {idl_kind, r_line, r_col, r_off, idl_len, 1'b1};
        push0    = tok_v ? rec_tok : rec_idl;
        push1    = rec_idl;
        push_cnt = accept ? (2'(tok_v) + 2'(idl_v)) : 2'd0;
    end

    ats_result_fifo #(
        .WIDTH (RW),
        .DEPTH (ATS_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cnt   (push_cnt),
        .i_push_data0 (push0),
        .i_push_data1 (push1),
        .i_pop        (!i_stall),
        .o_valid      (o_valid),
        .o_data       (out_rec),
        .o_room2      (room2)
    );

    assign o_stall = !room2;
    assign {o_token_kind, o_start_line, o_start_column, o_start_offset,
            o_token_length, o_last_of_run} = out_rec;

endmodule

`default_nettype wire

FILE: sv/ats_checker.sv
// port checks for the assembly token scanner and their binding to the top level
`default_nettype none

module ats_checker
    import ats_pkg::*;
#(
    parameter int POSITION_BITS = ATS_POSITION_BITS,
    parameter int OFFSET_BITS   = ATS_OFFSET_BITS,
    parameter int LENGTH_BITS   = ATS_LENGTH_BITS
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_out_valid,
    input wire logic                     i_out_stall,
    input wire logic [KIND_BITS-1:0]     i_kind,
    input wire logic [POSITION_BITS-1:0] i_line,
    input wire logic [POSITION_BITS-1:0] i_column,
    input wire logic [OFFSET_BITS-1:0]   i_offset,
    input wire logic [LENGTH_BITS-1:0]   i_length,
    input wire logic                     i_last
);

    // queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_kind) &&
            $stable(i_line) && $stable(i_column) && $stable(i_offset) &&
            $stable(i_length) && $stable(i_last))
        else $error("stalled result changed");

    // an end token closes the results of its byte and has no length
    a_end_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_END) |-> i_last && (i_length == '0))
        else $error("malformed end token");

    a_single_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_kind == KIND_COMMA) || (i_kind == KIND_ILLEGAL))
            |-> (i_length == LENGTH_BITS'(1)) && i_last)
        else $error("single byte token with wrong length");

    a_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_line != '0) && (i_column != '0))
        else $error("line or column zero");

endmodule

bind assembly_token_scanner_top ats_checker #(
    .POSITION_BITS (POSITION_BITS),
    .OFFSET_BITS   (OFFSET_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
) u_ats_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_kind      (o_token_kind),
    .i_line      (o_start_line),
    .i_column    (o_start_column),
    .i_offset    (o_start_offset),
    .i_length    (o_token_length),
    .i_last      (o_last_of_run)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// self-checking testbench for the assembly token scanner: random source against a predictor
`timescale 1ns / 1ps

module tb;
    import ats_pkg::*;

    localparam int MAIN_BYTES = 1400;
    localparam int TAIL_CALM  = 150;
    localparam int KEYWORDS   = 20;

    localparam logic [NUMBER_BITS-1:0]       NUMBER_TOP = '1;
    localparam logic [ATS_POSITION_BITS-1:0] POS_TOP    = '1;
    localparam logic [ATS_OFFSET_BITS-1:0]   OFF_TOP    = '1;
    localparam logic [ATS_LENGTH_BITS-1:0]   LEN_TOP    = '1;

    typedef struct packed {
        logic [KIND_BITS-1:0]         kind;
        logic [ATS_POSITION_BITS-1:0] line_no;
        logic [ATS_POSITION_BITS-1:0] col_no;
        logic [ATS_OFFSET_BITS-1:0]   offs;
        logic [ATS_LENGTH_BITS-1:0]   len;
        logic                         run_end;
    } t_token;

    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 drain;
    } t_src_byte;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic                         i_stall     = 1'b0;
    logic [CHAR_BITS-1:0]         i_char_byte = '0;
    logic                         o_stall;
    logic                         o_valid;
    logic [KIND_BITS-1:0]         o_token_kind;
    logic [ATS_POSITION_BITS-1:0] o_start_line;
    logic [ATS_POSITION_BITS-1:0] o_start_column;
    logic [ATS_OFFSET_BITS-1:0]   o_start_offset;
    logic [ATS_LENGTH_BITS-1:0]   o_token_length;
    logic                         o_last_of_run;

    assembly_token_scanner_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_byte    (i_char_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    always #10 i_clk = ~i_clk;

    t_mode                        lex_mode;
    logic [ATS_POSITION_BITS-1:0] cur_line;
    logic [ATS_POSITION_BITS-1:0] cur_col;
    logic [ATS_OFFSET_BITS-1:0]   cur_off;
    logic [ATS_POSITION_BITS-1:0] tok_line;
    logic [ATS_POSITION_BITS-1:0] tok_col;
    logic [ATS_OFFSET_BITS-1:0]   tok_off;
    logic [ATS_LENGTH_BITS-1:0]   tok_len;
    logic [PREFIX_BITS-1:0]       word_tail;
    logic [NUMBER_BITS-1:0]       num_val;
    logic                         num_ovf;

    t_token    tokens_due[$];
    t_token    made_now[$];
    t_src_byte source_q[$];

    int   error_count    = 0;
    int   tokens_checked = 0;
    logic byte_taken     = 1'b0;
    int   send_gap       = 0;
    int   hold_gap       = 0;
    int   quiet_left     = 0;
    int   digit_run      = 0;
    logic drain_next     = 1'b0;

    string keyword_list[KEYWORDS] = '{"halt", "add", "sub", "mul", "div", "push", "pop",
                                      "move", "cmp", "jmp", "je", "jne", "jg", "jl", "jge",
                                      "jle", "RA", "RB", "RC", "RD"};
    string near_miss[8] = '{"Halt", "haltx", "ra", "Rd", "jz", "ad", "moves", "RE"};

    function automatic logic is_letter(input logic [CHAR_BITS-1:0] b);
        return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
    endfunction

    function automatic logic is_digit(input logic [CHAR_BITS-1:0] b);
        return b >= CH_DIGIT0 && b <= CH_DIGIT9;
    endfunction

    function automatic logic is_blank(input logic [CHAR_BITS-1:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic [KIND_BITS-1:0] word_kind();
        logic [PREFIX_BITS-1:0] kw_bits;
        logic [KIND_BITS-1:0]   found;
        string                  word;
        int                     k;
        int                     i;
        found = KIND_END;
        for (k = 0; k < KEYWORDS; k++) begin
            word    = keyword_list[k];
            kw_bits = '0;
            for (i = 0; i < word.len(); i++)
                kw_bits = {kw_bits[PREFIX_BITS-9:0], word[i]};
            if (tok_len == word.len() && word_tail == kw_bits)
                found = KIND_BITS'(KIND_HALT + k);
        end
        return found;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic put_token(input logic [KIND_BITS-1:0] kind,
                             input logic [ATS_POSITION_BITS-1:0] ln,
                             input logic [ATS_POSITION_BITS-1:0] col,
                             input logic [ATS_OFFSET_BITS-1:0] off,
                             input logic [ATS_LENGTH_BITS-1:0] len);
        t_token t;
        t.kind    = kind;
        t.line_no = ln;
        t.col_no  = col;
        t.offs    = off;
        t.len     = len;
        t.run_end = 1'b0;
        if (made_now.size() < 2)
            made_now.push_back(t);
    endtask

    task automatic clear_scanner();
        lex_mode  = MODE_IDLE;
        cur_line  = ATS_POSITION_BITS'(1);
        cur_col   = ATS_POSITION_BITS'(1);
        cur_off   = '0;
        tok_line  = ATS_POSITION_BITS'(1);
        tok_col   = ATS_POSITION_BITS'(1);
        tok_off   = '0;
        tok_len   = '0;
        word_tail = '0;
        num_val   = '0;
        num_ovf   = 1'b0;
    endtask

    task automatic step_position(input logic [CHAR_BITS-1:0] b);
        if (b == CH_NEWLINE) begin
            if (cur_line != POS_TOP)
                cur_line++;
            cur_col = ATS_POSITION_BITS'(1);
        end else if (cur_col != POS_TOP) begin
            cur_col++;
        end
        if (cur_off != OFF_TOP)
            cur_off++;
    endtask

    task automatic mark_token_start();
        tok_line = cur_line;
        tok_col  = cur_col;
        tok_off  = cur_off;
    endtask

    task automatic stop_scanning();
        mark_token_start();
        lex_mode = MODE_DONE;
    endtask

    task automatic bump_length();
        if (tok_len != LEN_TOP)
            tok_len++;
    endtask

    task automatic scan_between(input logic [CHAR_BITS-1:0] b);
        if (b == CH_NUL) begin
            put_token(KIND_END, cur_line, cur_col, cur_off, '0);
            stop_scanning();
        end else if (is_blank(b)) begin
            step_position(b);
        end else if (b == CH_SEMI) begin
            lex_mode = MODE_COMMENT;
            step_position(b);
        end else if (b == CH_COMMA) begin
            put_token(KIND_COMMA, cur_line, cur_col, cur_off, ATS_LENGTH_BITS'(1));
            step_position(b);
        end else if (is_letter(b)) begin
            mark_token_start();
            tok_len   = ATS_LENGTH_BITS'(1);
            word_tail = {24'h000000, b};
            lex_mode  = MODE_WORD;
            step_position(b);
        end else if (is_digit(b)) begin
            mark_token_start();
            tok_len  = ATS_LENGTH_BITS'(1);
            num_val  = NUMBER_BITS'(b - CH_DIGIT0);
            num_ovf  = 1'b0;
            lex_mode = MODE_NUMBER;
            step_position(b);
        end else begin
            put_token(KIND_ILLEGAL, cur_line, cur_col, cur_off, ATS_LENGTH_BITS'(1));
            stop_scanning();
        end
    endtask

    task automatic scan_byte(input logic [CHAR_BITS-1:0] b);
        logic [KIND_BITS-1:0]   kw;
        logic [NUMBER_BITS-1:0] digit;
        t_token                 t;
        made_now.delete();
        case (lex_mode)
            MODE_IDLE: scan_between(b);
            MODE_WORD: begin
                if (is_letter(b)) begin
                    word_tail = {word_tail[PREFIX_BITS-9:0], b};
                    bump_length();
                    step_position(b);
                end else begin
                    kw       = word_kind();
                    lex_mode = MODE_IDLE;
                    if (kw != KIND_END) begin
                        put_token(kw, tok_line, tok_col, tok_off, tok_len);
                        scan_between(b);
                    end else if (b == CH_COLON) begin
                        put_token(KIND_LABEL, tok_line, tok_col, tok_off, tok_len);
                        step_position(b);
                    end else begin
                        put_token(KIND_IDENT, tok_line, tok_col, tok_off, tok_len);
                        scan_between(b);
                    end
                end
            end
            MODE_NUMBER: begin
                if (is_digit(b)) begin
                    digit = NUMBER_BITS'(b - CH_DIGIT0);
                    if (num_val > (NUMBER_TOP - digit) / 10)
                        num_ovf = 1'b1;
                    num_val = num_val * 10 + digit;
                    bump_length();
                    step_position(b);
                end else if (num_ovf) begin
                    put_token(KIND_OVERFLOW, tok_line, tok_col, tok_off, tok_len);
                    stop_scanning();
                end else begin
                    put_token(KIND_IMM, tok_line, tok_col, tok_off, tok_len);
                    lex_mode = MODE_IDLE;
                    scan_between(b);
                end
            end
            MODE_COMMENT: begin
                if (b == CH_NUL) begin
                    put_token(KIND_END, cur_line, cur_col, cur_off, '0);
                    stop_scanning();
                end else begin
                    if (b == CH_NEWLINE)
                        lex_mode = MODE_IDLE;
                    step_position(b);
                end
            end
            default: begin
                lex_mode = MODE_DONE;
                put_token(KIND_END, tok_line, tok_col, tok_off, '0);
            end
        endcase
        if (made_now.size() > 0) begin
            t         = made_now.pop_back();
            t.run_end = 1'b1;
            made_now.push_back(t);
        end
        foreach (made_now[i])
            tokens_due.push_back(made_now[i]);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("token %0d %s: got %0d, expected %0d",
                                 tokens_checked, name, got, want));
    endtask

    task automatic check_token();
        t_token want;
        if (tokens_due.size() == 0) begin
            flag_error($sformatf("token kind %0d at offset %0d arrived with none pending",
                                 o_token_kind, o_start_offset));
        end else begin
            want = tokens_due.pop_front();
            compare_field("kind", 32'(o_token_kind), 32'(want.kind));
            compare_field("line", 32'(o_start_line), 32'(want.line_no));
            compare_field("column", 32'(o_start_column), 32'(want.col_no));
            compare_field("offset", 32'(o_start_offset), 32'(want.offs));
            compare_field("length", 32'(o_token_length), 32'(want.len));
            compare_field("last_of_run", 32'(o_last_of_run), 32'(want.run_end));
        end
        tokens_checked++;
    endtask

    // source text generation
    task automatic push_raw(input logic [CHAR_BITS-1:0] b);
        t_src_byte s;
        s.ch       = b;
        s.drain    = drain_next;
        drain_next = 1'b0;
        source_q.push_back(s);
        digit_run = is_digit(b) ? digit_run + 1 : 0;
    endtask

    // keeps digit runs short enough that no immediate can overflow
    task automatic push_char(input logic [CHAR_BITS-1:0] b);
        if (is_digit(b) && digit_run >= 19)
            push_raw(CH_SPACE);
        push_raw(b);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_raw(s[i]);
    endtask

    function automatic logic [CHAR_BITS-1:0] any_letter();
        if ($urandom_range(0, 1))
            return CH_UPPER_A + CHAR_BITS'($urandom_range(0, 25));
        return CH_LOWER_A + CHAR_BITS'($urandom_range(0, 25));
    endfunction

    function automatic logic [CHAR_BITS-1:0] any_blank();
        case ($urandom_range(0, 4))
            0: return CH_TAB;
            1: return 8'h0B;
            2: return 8'h0C;
            3: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic push_blanks(input int lo, input int hi);
        repeat ($urandom_range(lo, hi))
            push_raw(any_blank());
    endtask

    task automatic push_number();
        if ($urandom_range(0, 9) == 0) begin
            push_text("18446744073709551615");
        end else begin
            repeat ($urandom_range(1, 19))
                push_char(CH_DIGIT0 + CHAR_BITS'($urandom_range(0, 9)));
        end
    endtask

    task automatic push_comment();
        logic [CHAR_BITS-1:0] b;
        push_raw(CH_SEMI);
        repeat ($urandom_range(0, 12)) begin
            b = CHAR_BITS'($urandom_range(1, 255));
            if (b == CH_NEWLINE)
                b = CH_SPACE;
            push_raw(b);
        end
    endtask

    task automatic push_operand();
        case ($urandom_range(0, 5))
            0, 1: begin
                push_raw(CH_UPPER_A + CHAR_BITS'(17));
                push_raw(CH_UPPER_A + CHAR_BITS'($urandom_range(0, 3)));
            end
            2: repeat ($urandom_range(1, 7)) push_raw(any_letter());
            3: push_number();
            4: push_text(keyword_list[$urandom_range(0, KEYWORDS - 1)]);
            default: push_text(near_miss[$urandom_range(0, 7)]);
        endcase
    endtask

    task automatic push_noise();
        repeat ($urandom_range(4, 30)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: push_char(any_letter());
                3, 4: push_char(CH_DIGIT0 + CHAR_BITS'($urandom_range(0, 9)));
                5, 6: push_raw(any_blank());
                7: push_raw(CH_COMMA);
                8: push_raw(CH_NEWLINE);
                default: if ($urandom_range(0, 3) == 0) push_raw(CH_SEMI);
            endcase
        end
    endtask

    task automatic push_line();
        int form;
        int i;
        int n;
        if ($urandom_range(0, 29) == 0)
            drain_next = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
            // a leading uppercase L can never form a keyword
            push_raw(CH_UPPER_A + CHAR_BITS'(11));
            repeat ($urandom_range(0, 5)) push_raw(any_letter());
            push_raw(CH_COLON);
        end
        form = $urandom_range(0, 9);
        if (form < 6) begin
            push_blanks(0, 2);
            if ($urandom_range(0, 5) == 0)
                push_text(near_miss[$urandom_range(0, 7)]);
            else
                push_text(keyword_list[$urandom_range(0, 15)]);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) begin
                if (i == 0) begin
                    push_blanks(1, 3);
                end else begin
                    push_blanks(0, 2);
                    push_raw(CH_COMMA);
                    push_blanks(0, 2);
                end
                push_operand();
            end
        end else if (form < 8) begin
            push_noise();
        end else begin
            push_comment();
            push_raw(CH_NEWLINE);
            push_comment();
        end
        if ($urandom_range(0, 2) == 0) begin
            push_blanks(0, 1);
            push_comment();
        end
        if ($urandom_range(0, 4) == 0)
            push_raw(CH_CR);
        push_raw(CH_NEWLINE);
    endtask

    task automatic push_ending();
        logic [CHAR_BITS-1:0] b;
        push_raw(CH_NEWLINE);
        case ($urandom_range(0, 5))
            0: push_raw(CH_NUL);
            1: begin
                push_text(keyword_list[$urandom_range(0, KEYWORDS - 1)]);
                push_raw(CH_NUL);
            end
            2: begin
                push_text("; stop here");
                push_raw(CH_NUL);
            end
            3: begin
                b = CHAR_BITS'($urandom_range(1, 255));
                while (is_blank(b) || is_letter(b) || is_digit(b) || b == CH_SEMI
                       || b == CH_COMMA)
                    b = CHAR_BITS'($urandom_range(1, 255));
                push_raw(b);
            end
            4: begin
                repeat (25) push_raw(CH_DIGIT9);
                push_raw(CH_SPACE);
            end
            default: begin
                push_text("42");
                push_raw(CH_NUL);
            end
        endcase
    endtask

    task automatic build_source();
        logic long_word_done;
        logic long_zeros_done;
        long_word_done  = 1'b0;
        long_zeros_done = 1'b0;
        push_text("jle RD,18446744073709551615;c\n;\nL:\n");
        drain_next = 1'b1;
        while (source_q.size() < MAIN_BYTES) begin
            if (!long_word_done && source_q.size() > 500) begin
                repeat (300) push_raw(any_letter());
                push_raw(CH_NEWLINE);
                long_word_done = 1'b1;
            end
            if (!long_zeros_done && source_q.size() > 1000) begin
                repeat (280) push_raw(CH_DIGIT0);
                push_raw(CH_DIGIT0 + CHAR_BITS'(7));
                push_raw(CH_NEWLINE);
                long_zeros_done = 1'b1;
            end
            push_line();
        end
        push_ending();
        repeat (40) push_raw(CHAR_BITS'($urandom_range(0, 255)));
    endtask

    // transfer acceptance, prediction and checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scanner();
            byte_taken <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                check_token();
            if (i_valid && !o_stall)
                scan_byte(i_char_byte);
            byte_taken <= i_valid && !o_stall;
        end
    end

    // sender and receiver sides
    always @(negedge i_clk) begin : drive_side
        t_src_byte nxt;
        logic      calm;
        if (quiet_left > 0)
            quiet_left--;
        else if ($urandom_range(0, 99) == 0)
            quiet_left = $urandom_range(20, 60);
        calm = source_q.size() < TAIL_CALM || quiet_left > 0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            if (i_valid && !byte_taken) begin
                // payload held while stalled
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(1, 16) - 1;
                i_valid <= 1'b0;
            end else if (source_q.size() > 0
                         && (!source_q[0].drain || tokens_due.size() == 0)) begin
                nxt = source_q.pop_front();
                i_valid     <= 1'b1;
                i_char_byte <= nxt.ch;
            end else begin
                i_valid <= 1'b0;
            end
            if (hold_gap > 0) begin
                hold_gap--;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                hold_gap = $urandom_range(1, 16) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        build_source();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (source_q.size() > 0 || i_valid)
            @(posedge i_clk);
        while (tokens_due.size() > 0)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && tokens_due.size() == 0) begin
            $display("assembly_token_scanner_top test passed");
        end else begin
            $display("assembly_token_scanner_top test failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("assembly_token_scanner_top test failed");
        $finish;
    end

endmodule
